>>> src/vorticity_stencil_update_top_macros.svh
// Assertion macros for the vorticity stencil update block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef VORTICITY_STENCIL_UPDATE_TOP_MACROS_SVH
`define VORTICITY_STENCIL_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define VSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define VSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/vsu_pkg.sv
// Shared types, constants and helpers for the vorticity stencil update block.
// No dependencies; the design modules, the checker and the testbench import this package.
package vsu_pkg;

	// Number format
	localparam int VALUE_WIDTH   = 48;
	localparam int FRACTION_BITS = 24;
	localparam int GRID_W        = 12;
	localparam int COEF_W        = 25;
	localparam int CHANGE_W      = VALUE_WIDTH - 1;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;

	localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [CHANGE_W-1:0] CHANGE_MAX = '1;

	// Register reset values
	localparam logic [GRID_W-1:0] GRID_RST = GRID_W'(63);
	localparam logic [COEF_W-1:0] NU_RST   = COEF_W'(167772);
	localparam logic [COEF_W-1:0] DT_RST   = COEF_W'(41943);

	// Register bus
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_GRID = PADDR_W'(0);
	localparam logic [PADDR_W-1:0] ADDR_NU   = PADDR_W'(4);
	localparam logic [PADDR_W-1:0] ADDR_DT   = PADDR_W'(8);
	localparam logic [PADDR_W-1:0] ADDR_MODE = PADDR_W'(12);

	typedef struct packed {
		logic [GRID_W-1:0] grid;
		logic [COEF_W-1:0] nu;
		logic [COEF_W-1:0] dt;
		logic              central;
	} cfg_t;

	// One classified grid point on its way from front to back
	typedef struct packed {
		logic sweep_start;
		logic interior;
		val_t wc;
		val_t ww;
		val_t we;
		val_t ws;
		val_t wn;
		val_t ux;
		val_t vy;
		val_t dx;
		val_t dy;
	} item_t;

	localparam int QUEUE_DEPTH = 2;

	// Shared multiplier
	localparam int MUL_CHUNK = 16;
	localparam int MUL_STEPS = (VALUE_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int MUL_PAD   = MUL_STEPS * MUL_CHUNK;
	localparam int PROD_W    = 2 * VALUE_WIDTH;
	localparam int STEP_W    = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

	localparam logic [PROD_W-1:0] PROD_POS_LIM =
		{{(PROD_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [PROD_W-1:0] PROD_NEG_LIM = PROD_POS_LIM + PROD_W'(1);

	typedef enum logic [1:0] {SH_ZERO, SH_ONE, SH_FRAC} mul_sh_t;
	typedef enum logic [1:0] {MP_IDLE, MP_ACC, MP_ROUND, MP_SAT} mul_phase_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] a_mag;
		logic [VALUE_WIDTH-1:0] b_mag;
		logic                   neg;
		mul_sh_t                sh;
	} mul_req_t;

	// Back-end sequencer program
	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_t;
	typedef enum logic [3:0] {
		SRC_WC, SRC_WW, SRC_WE, SRC_WS, SRC_WN, SRC_UX, SRC_VY, SRC_DX,
		SRC_DY, SRC_G, SRC_NU, SRC_DT, SRC_FOUR, SRC_T0, SRC_T1, SRC_T2
	} src_t;
	localparam int NUM_SRC = 16;
	typedef enum logic [1:0] {PS_ZERO, PS_GRAD, PS_FRAC} prog_sh_t;
	typedef enum logic [1:0] {DST_T0, DST_T1, DST_T2} dst_t;

	typedef struct packed {
		op_t      op;
		src_t     src_a;
		src_t     src_b;
		prog_sh_t sh;
		dst_t     dst;
	} step_t;

	localparam int PROG_LEN = 17;
	localparam int PC_W     = $clog2(PROG_LEN);

	localparam step_t PROGRAM [PROG_LEN] = '{
		'{OP_MUL, SRC_DX, SRC_G,    PS_GRAD, DST_T0},  // gx
		'{OP_MUL, SRC_DY, SRC_G,    PS_GRAD, DST_T1},  // gy
		'{OP_MUL, SRC_UX, SRC_T0,   PS_FRAC, DST_T0},  // u*gx
		'{OP_MUL, SRC_VY, SRC_T1,   PS_FRAC, DST_T1},  // v*gy
		'{OP_ADD, SRC_T0, SRC_T1,   PS_ZERO, DST_T0},  // convection
		'{OP_ADD, SRC_WN, SRC_WS,   PS_ZERO, DST_T1},
		'{OP_ADD, SRC_T1, SRC_WE,   PS_ZERO, DST_T1},
		'{OP_ADD, SRC_T1, SRC_WW,   PS_ZERO, DST_T1},
		'{OP_MUL, SRC_WC, SRC_FOUR, PS_ZERO, DST_T2},  // 4*wc
		'{OP_SUB, SRC_T1, SRC_T2,   PS_ZERO, DST_T1},  // stencil sum
		'{OP_MUL, SRC_G,  SRC_G,    PS_ZERO, DST_T2},  // g*g
		'{OP_MUL, SRC_T1, SRC_T2,   PS_ZERO, DST_T1},  // laplacian
		'{OP_MUL, SRC_NU, SRC_T1,   PS_FRAC, DST_T1},  // diffusion
		'{OP_SUB, SRC_T1, SRC_T0,   PS_ZERO, DST_T1},  // rate
		'{OP_MUL, SRC_DT, SRC_T1,   PS_FRAC, DST_T1},  // delta
		'{OP_ADD, SRC_WC, SRC_T1,   PS_ZERO, DST_T1},  // new value
		'{OP_SUB, SRC_T1, SRC_WC,   PS_ZERO, DST_T2}   // change
	};

	typedef enum logic [2:0] {BK_IDLE, BK_ISSUE, BK_WAIT, BK_ABS, BK_MAX} back_state_t;

	// Exact add or subtract, saturated to the value range
	function automatic val_t sat_addsub(val_t a, val_t b, logic sub);
		logic signed [VALUE_WIDTH:0] s;
		val_t                        r;
		if (sub) begin
			s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
		end else begin
			s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
		end
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			r = s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
		end else begin
			r = s[VALUE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/vsu_front.sv
// Front end: accepts grid points, takes the gradient differences, pushes
// classified items into the queue. Depends on vsu_pkg.
module vsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           sweep_start,
	input  logic           interior,
	input  vsu_pkg::val_t  w_center,
	input  vsu_pkg::val_t  w_west,
	input  vsu_pkg::val_t  w_east,
	input  vsu_pkg::val_t  w_south,
	input  vsu_pkg::val_t  w_north,
	input  vsu_pkg::val_t  vel_x,
	input  vsu_pkg::val_t  vel_y,
	input  logic           central,
	input  logic           q_full,
	output logic           q_push,
	output vsu_pkg::item_t q_item
);
	import vsu_pkg::*;

	logic valid_s1;
	logic sweep_s1;
	logic interior_s1;
	val_t wc_s1, ww_s1, we_s1, ws_s1, wn_s1, ux_s1, vy_s1;
	val_t dxa, dxb, dya, dyb;

	assign q_push   = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	// Hold the accepted item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sweep_s1    <= sweep_start;
			interior_s1 <= interior;
			wc_s1       <= w_center;
			ww_s1       <= w_west;
			we_s1       <= w_east;
			ws_s1       <= w_south;
			wn_s1       <= w_north;
			ux_s1       <= vel_x;
			vy_s1       <= vel_y;
		end
	end

	// Pick difference operands: central span or upwind side by velocity sign
	always_comb begin
		if (central) begin
			dxa = we_s1;
			dxb = ww_s1;
			dya = wn_s1;
			dyb = ws_s1;
		end else begin
			dxa = ux_s1[VALUE_WIDTH-1] ? we_s1 : wc_s1;
			dxb = ux_s1[VALUE_WIDTH-1] ? wc_s1 : ww_s1;
			dya = vy_s1[VALUE_WIDTH-1] ? wn_s1 : wc_s1;
			dyb = vy_s1[VALUE_WIDTH-1] ? wc_s1 : ws_s1;
		end
	end

	always_comb begin
		q_item.sweep_start = sweep_s1;
		q_item.interior    = interior_s1;
		q_item.wc          = wc_s1;
		q_item.ww          = ww_s1;
		q_item.we          = we_s1;
		q_item.ws          = ws_s1;
		q_item.wn          = wn_s1;
		q_item.ux          = ux_s1;
		q_item.vy          = vy_s1;
		q_item.dx          = sat_addsub(dxa, dxb, 1'b1);
		q_item.dy          = sat_addsub(dya, dyb, 1'b1);
	end

endmodule

>>> src/vsu_queue.sv
// Short FIFO between front and back end.
// Depends on vsu_pkg for the item type and depth.
module vsu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vsu_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output vsu_pkg::item_t head,
	output logic           empty
);
	import vsu_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> src/vsu_mul.sv
// Shared multi-cycle multiplier: sign-magnitude product, rounding shift and
// saturation, one 16-bit chunk of the second operand per cycle. Uses vsu_pkg.
module vsu_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  vsu_pkg::mul_req_t req,
	output logic              done,
	output vsu_pkg::val_t     res
);
	import vsu_pkg::*;

	mul_phase_t                    phase_q, phase_d;
	logic [STEP_W-1:0]             cnt_q;
	logic [VALUE_WIDTH-1:0]        a_q;
	logic [MUL_PAD-1:0]            b_q;
	logic                          neg_q;
	mul_sh_t                       sh_q;
	logic [PROD_W-1:0]             acc_q;
	logic [VALUE_WIDTH+MUL_CHUNK-1:0] partial;
	logic [PROD_W-1:0]             half;
	logic [PROD_W-1:0]             shifted;
	val_t                          sat_val;
	val_t                          res_q;
	logic                          done_q;

	assign done = done_q;
	assign res  = res_q;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			MP_IDLE:  if (req.start) phase_d = MP_ACC;
			MP_ACC:   if (cnt_q == '0) phase_d = MP_ROUND;
			MP_ROUND: phase_d = MP_SAT;
			MP_SAT:   phase_d = MP_IDLE;
			default:  phase_d = MP_IDLE;
		endcase
	end

	// Datapath terms
	always_comb begin
		partial = a_q * b_q[MUL_PAD-1 -: MUL_CHUNK];
		case (sh_q)
			SH_ONE: begin
				half    = PROD_W'(1);
				shifted = acc_q >> 1;
			end
			SH_FRAC: begin
				half    = PROD_W'(1) << (FRACTION_BITS - 1);
				shifted = acc_q >> FRACTION_BITS;
			end
			default: begin
				half    = '0;
				shifted = acc_q;
			end
		endcase
		if (!neg_q) begin
			sat_val = (shifted > PROD_POS_LIM) ? VAL_MAX : val_t'(shifted[VALUE_WIDTH-1:0]);
		end else begin
			sat_val = (shifted > PROD_NEG_LIM) ? VAL_MIN
				: val_t'(~shifted[VALUE_WIDTH-1:0] + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == MP_SAT);
			if (phase_q == MP_IDLE && req.start) begin
				cnt_q <= STEP_W'(MUL_STEPS - 1);
			end else if (phase_q == MP_ACC && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Accumulate chunks from the top, then round, then saturate
	always_ff @(posedge clk) begin
		case (phase_q)
			MP_IDLE: begin
				if (req.start) begin
					a_q   <= req.a_mag;
					b_q   <= MUL_PAD'(req.b_mag);
					neg_q <= req.neg;
					sh_q  <= req.sh;
					acc_q <= '0;
				end
			end
			MP_ACC: begin
				acc_q <= (acc_q << MUL_CHUNK) + PROD_W'(partial);
				b_q   <= b_q << MUL_CHUNK;
			end
			MP_ROUND: acc_q <= acc_q + half;
			MP_SAT:   res_q <= sat_val;
			default:  ;
		endcase
	end

endmodule

>>> src/vsu_back.sv
// Back end: runs the update sequence on the shared multiplier and adder,
// keeps the running maximum and the output register. Uses vsu_pkg, vsu_mul.
module vsu_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vsu_pkg::cfg_t            cfg,
	input  logic                     q_empty,
	input  vsu_pkg::item_t           q_head,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output vsu_pkg::val_t            w_new,
	output logic [vsu_pkg::CHANGE_W-1:0] max_change
);
	import vsu_pkg::*;

	back_state_t           state_q, state_d;
	logic [PC_W-1:0]       pc_q;
	item_t                 item_q;
	val_t                  t0_q, t1_q, t2_q;
	logic [CHANGE_W-1:0]   chg_q;
	logic [CHANGE_W-1:0]   run_max_q;
	logic                  out_valid_q;
	val_t                  w_new_q;
	logic [CHANGE_W-1:0]   max_out_q;

	step_t                 step;
	val_t                  opnd [NUM_SRC];
	val_t                  a_val, b_val;
	val_t                  alu_res;
	logic                  last;
	mul_req_t              mreq;
	logic                  mul_done;
	val_t                  mul_res;
	logic                  wr_en;
	val_t                  wr_data;
	logic                  load_out;
	logic [VALUE_WIDTH-1:0] t2_mag;
	logic [CHANGE_W-1:0]   max_base;
	logic [CHANGE_W-1:0]   max_new;

	function automatic logic [VALUE_WIDTH-1:0] mag_of(val_t v);
		return v[VALUE_WIDTH-1] ? VALUE_WIDTH'(~v + 1'b1) : VALUE_WIDTH'(v);
	endfunction

	vsu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.res    (mul_res)
	);

	assign step = PROGRAM[pc_q];
	assign last = (pc_q == PC_W'(PROG_LEN - 1));

	// Operand selection
	always_comb begin
		opnd[SRC_WC]   = item_q.wc;
		opnd[SRC_WW]   = item_q.ww;
		opnd[SRC_WE]   = item_q.we;
		opnd[SRC_WS]   = item_q.ws;
		opnd[SRC_WN]   = item_q.wn;
		opnd[SRC_UX]   = item_q.ux;
		opnd[SRC_VY]   = item_q.vy;
		opnd[SRC_DX]   = item_q.dx;
		opnd[SRC_DY]   = item_q.dy;
		opnd[SRC_G]    = val_t'({{(VALUE_WIDTH-GRID_W){1'b0}}, cfg.grid});
		opnd[SRC_NU]   = val_t'({{(VALUE_WIDTH-COEF_W){1'b0}}, cfg.nu});
		opnd[SRC_DT]   = val_t'({{(VALUE_WIDTH-COEF_W){1'b0}}, cfg.dt});
		opnd[SRC_FOUR] = val_t'(4);
		opnd[SRC_T0]   = t0_q;
		opnd[SRC_T1]   = t1_q;
		opnd[SRC_T2]   = t2_q;
		a_val   = opnd[step.src_a];
		b_val   = opnd[step.src_b];
		alu_res = sat_addsub(a_val, b_val, step.op == OP_SUB);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) state_d = q_head.interior ? BK_ISSUE : BK_ABS;
			end
			BK_ISSUE: begin
				if (step.op == OP_MUL) begin
					state_d = BK_WAIT;
				end else if (last) begin
					state_d = BK_ABS;
				end
			end
			BK_WAIT: begin
				if (mul_done) state_d = last ? BK_ABS : BK_ISSUE;
			end
			BK_ABS: state_d = BK_MAX;
			BK_MAX: begin
				if (!out_valid_q || out_ready) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		q_pop      = (state_q == BK_IDLE) && !q_empty;
		mreq.start = (state_q == BK_ISSUE) && (step.op == OP_MUL);
		mreq.a_mag = mag_of(a_val);
		mreq.b_mag = mag_of(b_val);
		mreq.neg   = a_val[VALUE_WIDTH-1] ^ b_val[VALUE_WIDTH-1];
		case (step.sh)
			PS_GRAD: mreq.sh = cfg.central ? SH_ONE : SH_ZERO;
			PS_FRAC: mreq.sh = SH_FRAC;
			default: mreq.sh = SH_ZERO;
		endcase
		wr_en    = ((state_q == BK_ISSUE) && (step.op != OP_MUL))
			|| ((state_q == BK_WAIT) && mul_done);
		wr_data  = (state_q == BK_ISSUE) ? alu_res : mul_res;
		load_out = (state_q == BK_MAX) && (!out_valid_q || out_ready);
	end

	// Running maximum: clear at sweep start, then compare
	always_comb begin
		t2_mag   = mag_of(t2_q);
		max_base = item_q.sweep_start ? '0 : run_max_q;
		max_new  = (chg_q > max_base) ? chg_q : max_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pc_q        <= '0;
			run_max_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				pc_q <= '0;
			end else if (wr_en) begin
				pc_q <= pc_q + 1'b1;
			end
			if (load_out) begin
				run_max_q   <= max_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, temporaries, change magnitude, output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
			if (!q_head.interior) begin
				t1_q <= q_head.wc;
				t2_q <= '0;
			end
		end else if (wr_en) begin
			case (step.dst)
				DST_T0:  t0_q <= wr_data;
				DST_T1:  t1_q <= wr_data;
				DST_T2:  t2_q <= wr_data;
				default: ;
			endcase
		end
		if (state_q == BK_ABS) begin
			chg_q <= t2_mag[VALUE_WIDTH-1] ? CHANGE_MAX : t2_mag[CHANGE_W-1:0];
		end
		if (load_out) begin
			w_new_q   <= t1_q;
			max_out_q <= max_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign w_new      = w_new_q;
	assign max_change = max_out_q;

endmodule

>>> src/vorticity_stencil_update_top.sv
// An accepted interior item passes the front register and the queue to the
// back end, which runs nine multiplies on the shared multiplier and eight add
// steps, then takes the change magnitude and updates the running maximum; a
// boundary point skips the program. The back end holds one point at a time.
// Reset (arst_n low, asynchronous): queue empty, running maximum zero,
// registers at their documented defaults.
module vorticity_stencil_update_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vsu_pkg::PADDR_W-1:0]   paddr,
	input  logic [vsu_pkg::PDATA_W-1:0]   pwdata,
	output logic [vsu_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          sweep_start,
	input  logic                          interior,
	input  vsu_pkg::val_t                 w_center,
	input  vsu_pkg::val_t                 w_west,
	input  vsu_pkg::val_t                 w_east,
	input  vsu_pkg::val_t                 w_south,
	input  vsu_pkg::val_t                 w_north,
	input  vsu_pkg::val_t                 vel_x,
	input  vsu_pkg::val_t                 vel_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vsu_pkg::val_t                 w_new,
	output logic [vsu_pkg::CHANGE_W-1:0]  max_change
);
	import vsu_pkg::*;

	cfg_t  cfg_q;
	logic  q_push, q_full, q_pop, q_empty;
	item_t q_item, q_head;

	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid    <= GRID_RST;
			cfg_q.nu      <= NU_RST;
			cfg_q.dt      <= DT_RST;
			cfg_q.central <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr)
				ADDR_GRID: cfg_q.grid    <= pwdata[GRID_W-1:0];
				ADDR_NU:   cfg_q.nu      <= pwdata[COEF_W-1:0];
				ADDR_DT:   cfg_q.dt      <= pwdata[COEF_W-1:0];
				ADDR_MODE: cfg_q.central <= pwdata[0];
				default:   ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr)
			ADDR_GRID: prdata = PDATA_W'(cfg_q.grid);
			ADDR_NU:   prdata = PDATA_W'(cfg_q.nu);
			ADDR_DT:   prdata = PDATA_W'(cfg_q.dt);
			ADDR_MODE: prdata = PDATA_W'(cfg_q.central);
			default:   prdata = '0;
		endcase
	end

	vsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sweep_start (sweep_start),
		.interior    (interior),
		.w_center    (w_center),
		.w_west      (w_west),
		.w_east      (w_east),
		.w_south     (w_south),
		.w_north     (w_north),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.central     (cfg_q.central),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	vsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	vsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.w_new      (w_new),
		.max_change (max_change)
	);

endmodule

>>> src/vsu_checker.sv
// Port-level checker for the vorticity stencil update block, with its bind.
// Depends on vsu_pkg and the assertion macro header.
`include "vorticity_stencil_update_top_macros.svh"

module vsu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          pwrite,
	input logic [vsu_pkg::PADDR_W-1:0]   paddr,
	input logic [vsu_pkg::PDATA_W-1:0]   prdata,
	input logic                          pready,
	input logic                          out_valid,
	input logic                          out_ready,
	input vsu_pkg::val_t                 w_new,
	input logic [vsu_pkg::CHANGE_W-1:0]  max_change
);
	import vsu_pkg::*;

	// Register port never stalls
	`VSU_ASSERT_NOW(a_pready_high, 1'b1, pready, "register port not ready")

	// Readback carries no bits above the register width
	`VSU_ASSERT_NOW(a_mode_readback, psel && !pwrite && paddr == ADDR_MODE, prdata[PDATA_W-1:1] == '0, "mode readback wider than one bit")
	`VSU_ASSERT_NOW(a_grid_readback, psel && !pwrite && paddr == ADDR_GRID, prdata[PDATA_W-1:GRID_W] == '0, "grid readback too wide")

	// A result held back by the sink stays put
	`VSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(w_new) && $stable(max_change), "result changed while stalled")

endmodule

bind vorticity_stencil_update_top vsu_checker u_vsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.prdata     (prdata),
	.pready     (pready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.w_new      (w_new),
	.max_change (max_change)
);

>>> dv/tb_vorticity_stencil_update_top.sv
// Self-checking testbench for vorticity_stencil_update_top: streams grid points
// through the valid/ready ports under random back-pressure and compares every
// update with a local saturating fixed-point predictor. Depends on vsu_pkg.
module tb_vorticity_stencil_update_top ();
	timeunit 1ns;
	timeprecision 1ps;
	import vsu_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 100;

	typedef logic signed [127:0] wide_t;

	localparam wide_t WIDE_MAX = VAL_MAX;
	localparam wide_t WIDE_MIN = VAL_MIN;
	localparam val_t  UNIT     = val_t'(48'd1 << FRACTION_BITS);

	typedef struct {
		logic sweep_start;
		logic interior;
		val_t w_center;
		val_t w_west;
		val_t w_east;
		val_t w_south;
		val_t w_north;
		val_t vel_x;
		val_t vel_y;
	} stencil_point_t;

	typedef struct {
		val_t                w_new;
		logic [CHANGE_W-1:0] max_change;
	} stencil_result_t;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Block ports
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                sweep_start = 1'b0;
	logic                interior = 1'b0;
	val_t                w_center = '0;
	val_t                w_west = '0;
	val_t                w_east = '0;
	val_t                w_south = '0;
	val_t                w_north = '0;
	val_t                vel_x = '0;
	val_t                vel_y = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	val_t                w_new;
	logic [CHANGE_W-1:0] max_change;

	vorticity_stencil_update_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sweep_start(sweep_start),
		.interior   (interior),
		.w_center   (w_center),
		.w_west     (w_west),
		.w_east     (w_east),
		.w_south    (w_south),
		.w_north    (w_north),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.w_new      (w_new),
		.max_change (max_change)
	);

	// Testbench state
	stencil_point_t      pending_points[$];
	stencil_result_t     predicted_updates[$];
	cfg_t                shadow_cfg = '{grid: GRID_RST, nu: NU_RST, dt: DT_RST, central: 1'b0};
	logic [VALUE_WIDTH-1:0] peak_change = '0;
	logic                in_fire = 1'b0;
	logic                out_fire = 1'b0;
	bit                  idle_on = 1'b1;
	int unsigned         send_gap = 0;
	int unsigned         stall_left = 0;
	int unsigned         mismatch_count = 0;
	int unsigned         quiet_cycles = 0;

	// Saturate an exact value to the signed value range
	function automatic val_t clamp(wide_t x);
		if (x > WIDE_MAX) return VAL_MAX;
		if (x < WIDE_MIN) return VAL_MIN;
		return x[VALUE_WIDTH-1:0];
	endfunction

	function automatic val_t sat_sum(val_t a, val_t b, bit negate_b);
		wide_t wa, wb;
		wa = a;
		wb = b;
		return clamp(negate_b ? wa - wb : wa + wb);
	endfunction

	// Exact product, shifted right with ties rounded away from zero, saturated
	function automatic val_t scaled_product(wide_t a, wide_t b, int unsigned shift);
		wide_t p, m;
		p = a * b;
		m = (p < 0) ? -p : p;
		if (shift > 0) m = (m + (wide_t'(1) <<< (shift - 1))) >>> shift;
		return clamp((p < 0) ? -m : m);
	endfunction

	// Expected update for one grid point; advances the running peak
	function automatic stencil_result_t predict_update(stencil_point_t pt);
		stencil_result_t r;
		val_t  gx, gy, conv, lap_sum, lap, rate, delta, change;
		wide_t gw, mag, peak_w;
		gw = shadow_cfg.grid;
		r.w_new = pt.w_center;
		if (pt.sweep_start) peak_change = '0;
		if (pt.interior) begin
			if (shadow_cfg.central) begin
				gx = scaled_product(sat_sum(pt.w_east, pt.w_west, 1'b1), gw, 1);
				gy = scaled_product(sat_sum(pt.w_north, pt.w_south, 1'b1), gw, 1);
			end else begin
				gx = (pt.vel_x < 0) ? scaled_product(sat_sum(pt.w_east, pt.w_center, 1'b1), gw, 0)
					: scaled_product(sat_sum(pt.w_center, pt.w_west, 1'b1), gw, 0);
				gy = (pt.vel_y < 0) ? scaled_product(sat_sum(pt.w_north, pt.w_center, 1'b1), gw, 0)
					: scaled_product(sat_sum(pt.w_center, pt.w_south, 1'b1), gw, 0);
			end
			conv = sat_sum(scaled_product(pt.vel_x, gx, FRACTION_BITS),
				scaled_product(pt.vel_y, gy, FRACTION_BITS), 1'b0);
			lap_sum = sat_sum(sat_sum(sat_sum(pt.w_north, pt.w_south, 1'b0), pt.w_east, 1'b0),
				pt.w_west, 1'b0);
			lap_sum = sat_sum(lap_sum, scaled_product(pt.w_center, 4, 0), 1'b1);
			lap = scaled_product(lap_sum, gw * gw, 0);
			rate = sat_sum(scaled_product(shadow_cfg.nu, lap, FRACTION_BITS), conv, 1'b1);
			delta = scaled_product(shadow_cfg.dt, rate, FRACTION_BITS);
			r.w_new = sat_sum(pt.w_center, delta, 1'b0);
			change = sat_sum(r.w_new, pt.w_center, 1'b1);
			mag = change;
			if (mag < 0) mag = -mag;
			if (mag > WIDE_MAX) mag = WIDE_MAX;
			peak_w = peak_change;
			if (mag > peak_w) peak_change = mag[VALUE_WIDTH-1:0];
		end
		r.max_change = peak_change[CHANGE_W-1:0];
		return r;
	endfunction

	// Idle lengths: mostly none or short, a few long
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic val_t any_value();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[VALUE_WIDTH-1:0];
	endfunction

	// Random value with magnitude below 2^width_bits
	function automatic val_t near_value(int unsigned width_bits);
		logic [63:0] raw;
		val_t        v;
		raw = {$urandom, $urandom} & ((64'd1 << width_bits) - 64'd1);
		v = raw[VALUE_WIDTH-1:0];
		return ($urandom_range(1) == 1) ? -v : v;
	endfunction

	function automatic val_t corner_value();
		case ($urandom_range(4))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Mostly smooth fields around the centre, some wild and some corner points
	function automatic stencil_point_t random_point();
		stencil_point_t pt;
		int unsigned    kind, spread;
		pt.sweep_start = ($urandom_range(29) == 0);
		pt.interior = ($urandom_range(4) != 0);
		kind = $urandom_range(9);
		if (kind < 7) begin
			spread = $urandom_range(26, 4);
			pt.w_center = near_value($urandom_range(30, 8));
			pt.w_west = sat_sum(pt.w_center, near_value(spread), 1'b0);
			pt.w_east = sat_sum(pt.w_center, near_value(spread), 1'b0);
			pt.w_south = sat_sum(pt.w_center, near_value(spread), 1'b0);
			pt.w_north = sat_sum(pt.w_center, near_value(spread), 1'b0);
			pt.vel_x = near_value($urandom_range(26, 4));
			pt.vel_y = near_value($urandom_range(26, 4));
		end else if (kind < 9) begin
			pt.w_center = any_value();
			pt.w_west = any_value();
			pt.w_east = any_value();
			pt.w_south = any_value();
			pt.w_north = any_value();
			pt.vel_x = any_value();
			pt.vel_y = any_value();
		end else begin
			pt.w_center = corner_value();
			pt.w_west = corner_value();
			pt.w_east = corner_value();
			pt.w_south = corner_value();
			pt.w_north = corner_value();
			pt.vel_x = corner_value();
			pt.vel_y = corner_value();
		end
		return pt;
	endfunction

	task automatic add_point(logic ss, logic inner, val_t wc, val_t ww, val_t we,
		val_t ws, val_t wn, val_t ux, val_t vy);
		pending_points.push_back('{ss, inner, wc, ww, we, ws, wn, ux, vy});
	endtask

	// Velocity sign combinations, range extremes, boundary points, sweep restarts
	task automatic queue_directed_points();
		add_point(1, 1, 0, 0, 0, 0, 0, 0, 0);
		add_point(0, 1, UNIT, UNIT / 2, UNIT * 2, UNIT / 4, UNIT * 3 / 2, UNIT, UNIT / 2);
		add_point(0, 1, UNIT, UNIT / 2, UNIT * 2, UNIT / 4, UNIT * 3 / 2, -UNIT, -(UNIT / 2));
		add_point(0, 1, UNIT, -UNIT, UNIT * 3, UNIT / 4, -UNIT * 2, UNIT, -UNIT);
		add_point(0, 1, -UNIT, UNIT, -UNIT * 3, -UNIT / 4, UNIT * 2, -UNIT, UNIT);
		add_point(0, 1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
		add_point(0, 1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
		add_point(0, 1, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN);
		add_point(0, 1, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MAX);
		add_point(0, 0, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
		add_point(1, 0, -UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT);
		add_point(1, 1, 3, 0, 1, 0, 3, 0, 0);
		add_point(0, 1, -1, 0, 0, 0, 0, 0, -1);
	endtask

	// Hold until every point is sent and every update has come back
	task automatic drain_block();
		while (pending_points.size() != 0 || in_valid || predicted_updates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(logic [PDATA_W-1:0] grid, nu, dt, mode);
		write_register(ADDR_GRID, grid);
		write_register(ADDR_NU, nu);
		write_register(ADDR_DT, dt);
		write_register(ADDR_MODE, mode);
	endtask

	task automatic run_phase(int unsigned random_count, bit with_directed);
		if (with_directed) queue_directed_points();
		repeat (random_count) pending_points.push_back(random_point());
		drain_block();
	endtask

	// Drive points: hold until accepted, then idle or advance
	always @(negedge clk) begin : point_source
		stencil_point_t pt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				pt = pending_points.pop_front();
				sweep_start <= pt.sweep_start;
				interior <= pt.interior;
				w_center <= pt.w_center;
				w_west <= pt.w_west;
				w_east <= pt.w_east;
				w_south <= pt.w_south;
				w_north <= pt.w_north;
				vel_x <= pt.vel_x;
				vel_y <= pt.vel_y;
				in_valid <= 1'b1;
				send_gap = idle_on ? gap_length() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side, mostly after a taken item
	always @(negedge clk) begin : update_sink
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0 && idle_on && (out_fire || $urandom_range(15) == 0))
				stall_left = gap_length();
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Track register writes, predict accepted points, check returned updates
	always @(posedge clk) begin : update_checker
		stencil_result_t want;
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_GRID: shadow_cfg.grid = pwdata[GRID_W-1:0];
					ADDR_NU:   shadow_cfg.nu = pwdata[COEF_W-1:0];
					ADDR_DT:   shadow_cfg.dt = pwdata[COEF_W-1:0];
					ADDR_MODE: shadow_cfg.central = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predicted_updates.push_back(predict_update('{sweep_start, interior, w_center,
					w_west, w_east, w_south, w_north, vel_x, vel_y}));
			if (out_valid && out_ready) begin
				if (predicted_updates.size() == 0) begin
					$error("update item with no point outstanding: w_new %0d", w_new);
					mismatch_count++;
				end else begin
					want = predicted_updates.pop_front();
					if (w_new !== want.w_new) begin
						$error("w_new: expected %0d, got %0d", want.w_new, w_new);
						mismatch_count++;
					end
					if (max_change !== want.max_change) begin
						$error("max_change: expected %0d, got %0d", want.max_change, max_change);
						mismatch_count++;
					end
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** vorticity_stencil_update_top: FAILED **");
			$finish;
		end
	end

	initial begin : sequencer
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults, upwind
		run_phase(100, 1'b1);

		// Largest grid and coefficients above one, central differences
		idle_on = 1'b1;
		configure(32'd4095, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'd1);
		run_phase(60, 1'b1);

		// Zero grid and coefficients; upper bits of grid and mode are dropped
		idle_on = 1'b0;
		configure(32'hFFFF_F000, 32'd0, 32'd0, 32'd2);
		run_phase(60, 1'b0);

		// Smallest legal grid, unit coefficients, no idling at all
		configure(32'd7, 32'd16777216, 32'd16777216, 32'd0);
		run_phase(100, 1'b0);

		idle_on = 1'b1;
		configure(32'd127, $urandom_range(16777216), $urandom_range(1 << 22), 32'd1);
		run_phase(150, 1'b0);

		configure($urandom_range(4095, 7), $urandom_range(16777216), $urandom_range(16777216),
			32'd0);
		run_phase(150, 1'b0);

		idle_on = 1'b0;
		configure(32'd1, 32'd167772, 32'd41943, 32'd1);
		run_phase(60, 1'b0);

		// Central selected through the low bit of a wider value
		idle_on = 1'b1;
		configure(32'd63, 32'd167772, 32'd41943, 32'd3);
		run_phase(100, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && predicted_updates.size() == 0) begin
			$display("** vorticity_stencil_update_top: PASSED **");
		end else begin
			$display("** vorticity_stencil_update_top: FAILED **");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/vsu_pkg.sv
src/vsu_front.sv
src/vsu_queue.sv
src/vsu_mul.sv
src/vsu_back.sv
src/vorticity_stencil_update_top.sv
src/vsu_checker.sv
dv/tb_vorticity_stencil_update_top.sv
